/* hdl/tcbha_pkg.sv */
// ----------------------------------------------------------------------------
// tcbha_pkg
// Shared constants, types and helper functions of the two-class block heap
// allocator: block geometry, owner table sizing, command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package tcbha_pkg;

	localparam int TABLE_DEPTH  = 12;
	localparam int SMALL_BLOCKS = 24;
	localparam int TOTAL_BLOCKS = 40;
	localparam int LARGE_BLOCKS = TOTAL_BLOCKS - SMALL_BLOCKS;

	localparam int ADDR_W  = 32;
	localparam int OWNER_W = 32;
	localparam int SIZE_W  = 16;
	localparam int FREED_W = 4;

	localparam int SMALL_SHIFT = 9;
	localparam int LARGE_SHIFT = 10;
	localparam int SMALL_BYTES = 1 << SMALL_SHIFT;
	localparam int LARGE_BYTES = 1 << LARGE_SHIFT;

	localparam int BLK_W  = $clog2(TOTAL_BLOCKS);
	localparam int SPAN_W = BLK_W + 1;
	localparam int SLOT_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(LARGE_BLOCKS + 1);
	localparam int NEED_W = SIZE_W - LARGE_SHIFT + 1;

	localparam logic [ADDR_W-1:0] HEAP_BASE_RST = 32'h2000_1000;

	localparam logic FUNC_ALLOC   = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic start;     // latch a new transaction
		logic a_step;    // one block of the map scan
		logic a_commit;  // claim the found run and write the table
		logic r_find;    // look at one table entry for the release address
		logic r_free;    // free one table entry if it belongs to the victim
		logic out_load;  // move the result into the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic func;
		logic alloc_ok;   // owner nonzero and a table entry is empty
		logic scan_hit;
		logic scan_last;
		logic find_hit;
		logic tbl_last;
		logic out_busy;
	} sts_t;

	function automatic logic [ADDR_W-1:0] blk_addr(input logic [ADDR_W-1:0] base,
			input logic [BLK_W-1:0] idx);
		logic [ADDR_W-1:0] a;
		if (idx < BLK_W'(SMALL_BLOCKS)) begin
			a = base + (ADDR_W'(idx) << SMALL_SHIFT);
		end else begin
			a = base + ADDR_W'(SMALL_BLOCKS * SMALL_BYTES)
				+ (ADDR_W'(idx - BLK_W'(SMALL_BLOCKS)) << LARGE_SHIFT);
		end
		return a;
	endfunction

	// bits lo .. hi-1 set
	function automatic logic [TOTAL_BLOCKS-1:0] range_mask(input logic [BLK_W-1:0] lo,
			input logic [SPAN_W-1:0] hi);
		logic [TOTAL_BLOCKS-1:0] m;
		for (int i = 0; i < TOTAL_BLOCKS; i++) begin
			m[i] = (SPAN_W'(i) >= SPAN_W'(lo)) && (SPAN_W'(i) < hi);
		end
		return m;
	endfunction

endpackage

`default_nettype wire

/* hdl/tcbha_ctrl.sv */
// ----------------------------------------------------------------------------
// tcbha_ctrl
// Sequencer of the allocator: decodes a transaction, steps the block map scan
// or the two owner table walks, and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcbha_ctrl
	import tcbha_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  sts_t      sts,
	output cmd_t      cmd
);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b000_0001,
		S_DECODE  = 7'b000_0010,
		S_ASCAN   = 7'b000_0100,
		S_ACOMMIT = 7'b000_1000,
		S_RFIND   = 7'b001_0000,
		S_RFREE   = 7'b010_0000,
		S_DONE    = 7'b100_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.func == FUNC_RELEASE) begin
					state_d = S_RFIND;
				end else if (sts.alloc_ok) begin
					state_d = S_ASCAN;
				end else begin
					state_d = S_DONE;
				end
			end
			S_ASCAN: begin
				cmd.a_step = 1'b1;
				if (sts.scan_hit) begin
					state_d = S_ACOMMIT;
				end else if (sts.scan_last) begin
					state_d = S_DONE;
				end
			end
			S_ACOMMIT: begin
				cmd.a_commit = 1'b1;
				state_d      = S_DONE;
			end
			S_RFIND: begin
				cmd.r_find = 1'b1;
				if (sts.find_hit) begin
					state_d = S_RFREE;
				end else if (sts.tbl_last) begin
					state_d = S_DONE;
				end
			end
			S_RFREE: begin
				cmd.r_free = 1'b1;
				if (sts.tbl_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* hdl/tcbha_dp.sv */
// ----------------------------------------------------------------------------
// tcbha_dp
// Datapath of the allocator: block map, owner table, heap base register,
// scan counters and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcbha_dp
	import tcbha_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [ADDR_W-1:0]   cfg_wdata,
	input  wire logic                func,
	input  wire logic [SIZE_W-1:0]   size_bytes,
	input  wire logic [OWNER_W-1:0]  owner,
	input  wire logic [ADDR_W-1:0]   release_address,
	input  wire logic                out_ready,
	input  cmd_t                     cmd,
	output sts_t                     sts,
	output logic                     out_valid,
	output logic [ADDR_W-1:0]        granted_address,
	output logic                     success,
	output logic [FREED_W-1:0]       entries_released
);

	logic [ADDR_W-1:0]       heap_base_q;
	logic [TOTAL_BLOCKS-1:0] map_q;
	logic [OWNER_W-1:0]      tbl_owner_q [TABLE_DEPTH];
	logic [BLK_W-1:0]        tbl_first_q [TABLE_DEPTH];
	logic [CNT_W-1:0]        tbl_count_q [TABLE_DEPTH];
	logic                    out_valid_q;

	logic                    func_q;
	logic [OWNER_W-1:0]      owner_q;
	logic [ADDR_W-1:0]       addr_q;
	logic [NEED_W-1:0]       need_q;
	logic [NEED_W-1:0]       run_q;
	logic [BLK_W-1:0]        idx_q;
	logic [BLK_W-1:0]        start_q;
	logic [BLK_W-1:0]        end_q;
	logic [SLOT_W-1:0]       k_q;
	logic [OWNER_W-1:0]      victim_q;
	logic [FREED_W-1:0]      freed_q;
	logic [ADDR_W-1:0]       res_addr_q;
	logic                    res_ok_q;
	logic [ADDR_W-1:0]       out_addr_q;
	logic                    out_ok_q;
	logic [FREED_W-1:0]      out_cnt_q;

	logic                    slot_free;
	logic [SLOT_W-1:0]       slot_idx;
	logic [NEED_W-1:0]       run_n;
	logic [NEED_W-1:0]       need_in;
	logic                    scan_hit;
	logic                    find_hit;
	logic                    victim_match;
	logic [TOTAL_BLOCKS-1:0] set_mask;
	logic [TOTAL_BLOCKS-1:0] clr_mask;

	// lowest empty table entry
	always_comb begin
		slot_free = 1'b0;
		slot_idx  = '0;
		for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
			if (tbl_owner_q[k] == '0) begin
				slot_free = 1'b1;
				slot_idx  = SLOT_W'(k);
			end
		end
	end

	always_comb begin
		if (size_bytes >= SIZE_W'(LARGE_BYTES)) begin
			need_in = NEED_W'(((SIZE_W+1)'(size_bytes) + (SIZE_W+1)'(LARGE_BYTES - 1))
				>> LARGE_SHIFT);
		end else begin
			need_in = NEED_W'(1);
		end
	end

	// a free run of length need_q ends at idx_q
	assign run_n    = map_q[idx_q] ? '0 : run_q + NEED_W'(1);
	assign scan_hit = (run_n == need_q);

	assign find_hit = (tbl_owner_q[k_q] != '0)
		&& (blk_addr(heap_base_q, tbl_first_q[k_q]) == addr_q);
	assign victim_match = (tbl_owner_q[k_q] == victim_q);

	assign set_mask = range_mask(start_q, SPAN_W'(end_q) + SPAN_W'(1));
	assign clr_mask = range_mask(tbl_first_q[k_q],
		SPAN_W'(tbl_first_q[k_q]) + SPAN_W'(tbl_count_q[k_q]));

	always_comb begin
		sts           = '0;
		sts.func      = func_q;
		sts.alloc_ok  = (owner_q != '0) && slot_free;
		sts.scan_hit  = scan_hit;
		sts.scan_last = (idx_q == BLK_W'(TOTAL_BLOCKS - 1));
		sts.find_hit  = find_hit;
		sts.tbl_last  = (k_q == SLOT_W'(TABLE_DEPTH - 1));
		sts.out_busy  = out_valid_q && !out_ready;
	end

	// state with a reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q <= HEAP_BASE_RST;
			map_q       <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < TABLE_DEPTH; k++) begin
				tbl_owner_q[k] <= '0;
			end
		end else begin
			if (cfg_we) begin
				heap_base_q <= cfg_wdata;
			end
			if (cmd.a_commit) begin
				map_q                 <= map_q | set_mask;
				tbl_owner_q[slot_idx] <= owner_q;
			end else if (cmd.r_free && victim_match) begin
				map_q            <= map_q & ~clr_mask;
				tbl_owner_q[k_q] <= '0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.a_commit) begin
			tbl_first_q[slot_idx] <= start_q;
			tbl_count_q[slot_idx] <= CNT_W'(need_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			func_q     <= func;
			owner_q    <= owner;
			addr_q     <= release_address;
			need_q     <= need_in;
			run_q      <= '0;
			idx_q      <= (size_bytes <= SIZE_W'(SMALL_BYTES)) ? '0 : BLK_W'(SMALL_BLOCKS);
			k_q        <= '0;
			freed_q    <= '0;
			res_addr_q <= '0;
			res_ok_q   <= 1'b0;
		end
		if (cmd.a_step) begin
			run_q <= run_n;
			idx_q <= idx_q + BLK_W'(1);
			if (scan_hit) begin
				start_q <= BLK_W'(NEED_W'(idx_q) + NEED_W'(1) - need_q);
				end_q   <= idx_q;
			end
		end
		if (cmd.a_commit) begin
			res_addr_q <= blk_addr(heap_base_q, start_q);
			res_ok_q   <= 1'b1;
		end
		if (cmd.r_find) begin
			if (find_hit) begin
				victim_q <= tbl_owner_q[k_q];
				res_ok_q <= 1'b1;
				k_q      <= '0;
			end else begin
				k_q <= k_q + SLOT_W'(1);
			end
		end
		if (cmd.r_free) begin
			k_q <= k_q + SLOT_W'(1);
			if (victim_match) begin
				freed_q <= freed_q + FREED_W'(1);
			end
		end
		if (cmd.out_load) begin
			out_addr_q <= res_addr_q;
			out_ok_q   <= res_ok_q;
			out_cnt_q  <= freed_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign granted_address  = out_addr_q;
	assign success          = out_ok_q;
	assign entries_released = out_cnt_q;

endmodule

`default_nettype wire

/* hdl/two_class_block_heap_allocator.sv */
// Sequence: allocate passes decode, then unless refused a map scan of one bit per step and
//   a commit on a grant; release walks the 12-entry table once to find, and again on a hit.
// Throughput: one transaction at a time; the next is accepted once the result sits in the
//   output register, even if it has not been taken. A full output register stalls the result.
// Reset: arst_n clears the block map, the owner table and the controller; heap_base
//   returns to 0x20001000.
// ----------------------------------------------------------------------------
// two_class_block_heap_allocator
// Bitmap heap allocator with 24 small and 16 large blocks and an owner table;
// allocate by size, release frees every allocation of the owner found.
// ----------------------------------------------------------------------------
`default_nettype none

module two_class_block_heap_allocator
	import tcbha_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [ADDR_W-1:0]   cfg_wdata,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                func,
	input  wire logic [SIZE_W-1:0]   size_bytes,
	input  wire logic [OWNER_W-1:0]  owner,
	input  wire logic [ADDR_W-1:0]   release_address,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [ADDR_W-1:0]        granted_address,
	output logic                     success,
	output logic [FREED_W-1:0]       entries_released
);

	cmd_t cmd;
	sts_t sts;

	tcbha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tcbha_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.func             (func),
		.size_bytes       (size_bytes),
		.owner            (owner),
		.release_address  (release_address),
		.out_ready        (out_ready),
		.cmd              (cmd),
		.sts              (sts),
		.out_valid        (out_valid),
		.granted_address  (granted_address),
		.success          (success),
		.entries_released (entries_released)
	);

`ifndef SYNTH
	a_commit_legal: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.a_commit |-> (sts.alloc_ok && sts.func == FUNC_ALLOC))
		else $error("allocation committed without owner or free table entry");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.start, cmd.a_step, cmd.a_commit, cmd.r_find, cmd.r_free,
			cmd.out_load}))
		else $error("more than one datapath command in a cycle");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("new transaction taken while one is in progress");

	a_release_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && entries_released != '0) |-> (success && granted_address == '0))
		else $error("release result carries an address or lacks success");
`endif

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-class block heap allocator. Requests go in
// over valid/ready, and an in-bench copy of the block map and owner table
// predicts every response. Directed cases cover the size classes, a full table,
// owner release and moving heap_base. Random traffic follows under a long output hold-off
// and then in phases at several bases, with random stalls on both sides in all but one phase.
// ----------------------------------------------------------------------------
module tb;
	import tcbha_pkg::*;

	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic               ok;
		logic [FREED_W-1:0] freed;
	} heap_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [ADDR_W-1:0]   cfg_wdata = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                func = FUNC_ALLOC;
	logic [SIZE_W-1:0]   size_bytes = '0;
	logic [OWNER_W-1:0]  owner = '0;
	logic [ADDR_W-1:0]   release_address = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [ADDR_W-1:0]   granted_address;
	logic                success;
	logic [FREED_W-1:0]  entries_released;

	// shadow of the allocator state
	logic [ADDR_W-1:0]        shadow_base = HEAP_BASE_RST;
	logic [TOTAL_BLOCKS-1:0]  shadow_map = '0;
	logic [OWNER_W-1:0]       shadow_owner [TABLE_DEPTH];
	int                       shadow_first [TABLE_DEPTH];
	int                       shadow_count [TABLE_DEPTH];

	heap_result_t pending_results[$];
	heap_result_t oldest;
	int           errors = 0;
	bit           idle_on = 1'b1;
	int           rx_hold = 0;

	two_class_block_heap_allocator dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.func             (func),
		.size_bytes       (size_bytes),
		.owner            (owner),
		.release_address  (release_address),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.granted_address  (granted_address),
		.success          (success),
		.entries_released (entries_released)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// ---------------- prediction ----------------

	function automatic logic [ADDR_W-1:0] block_start(int i);
		if (i < SMALL_BLOCKS) begin
			return shadow_base + ADDR_W'(i * SMALL_BYTES);
		end
		return shadow_base + ADDR_W'(SMALL_BLOCKS * SMALL_BYTES + (i - SMALL_BLOCKS) * LARGE_BYTES);
	endfunction

	function automatic int first_free_block(int lo, int hi);
		for (int i = lo; i < hi; i++) begin
			if (!shadow_map[i]) return i;
		end
		return TOTAL_BLOCKS;
	endfunction

	function automatic heap_result_t grant_alloc(logic [SIZE_W-1:0] sz, logic [OWNER_W-1:0] who);
		heap_result_t r;
		int slot, start, need, run, small_free, large_free;
		r = '0;
		start = TOTAL_BLOCKS;
		need = 1;
		run = 0;
		if (who == '0) return r;
		slot = TABLE_DEPTH;
		for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
			if (shadow_owner[k] == '0) slot = k;
		end
		if (slot == TABLE_DEPTH) return r;
		small_free = first_free_block(0, SMALL_BLOCKS);
		large_free = first_free_block(SMALL_BLOCKS, TOTAL_BLOCKS);
		if (sz <= SMALL_BYTES) begin
			start = (small_free < TOTAL_BLOCKS) ? small_free : large_free;
		end else if (sz < LARGE_BYTES) begin
			start = large_free;
		end else begin
			need = (int'(sz) + LARGE_BYTES - 1) / LARGE_BYTES;
			// contiguous run search starts at the first free large block
			for (int j = large_free; j < TOTAL_BLOCKS; j++) begin
				run = shadow_map[j] ? 0 : run + 1;
				if (run == need) begin
					start = j + 1 - need;
					break;
				end
			end
		end
		if (start >= TOTAL_BLOCKS) return r;
		for (int b = start; b < start + need; b++) shadow_map[b] = 1'b1;
		shadow_owner[slot] = who;
		shadow_first[slot] = start;
		shadow_count[slot] = need;
		r.addr = block_start(start);
		r.ok = 1'b1;
		return r;
	endfunction

	function automatic heap_result_t free_owner(logic [ADDR_W-1:0] at);
		heap_result_t r;
		logic [OWNER_W-1:0] victim;
		bit found;
		int freed;
		r = '0;
		victim = '0;
		found = 1'b0;
		freed = 0;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			if (!found && shadow_owner[k] != '0 && block_start(shadow_first[k]) == at) begin
				victim = shadow_owner[k];
				found = 1'b1;
			end
		end
		if (!found) return r;
		// every entry of that owner goes, not only the one addressed
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			if (shadow_owner[k] == victim) begin
				for (int b = shadow_first[k]; b < shadow_first[k] + shadow_count[k]; b++)
					shadow_map[b] = 1'b0;
				shadow_owner[k] = '0;
				shadow_first[k] = 0;
				shadow_count[k] = 0;
				freed++;
			end
		end
		r.ok = 1'b1;
		r.freed = FREED_W'(freed);
		return r;
	endfunction

	function automatic int entries_in_use();
		int n;
		n = 0;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			if (shadow_owner[k] != '0) n++;
		end
		return n;
	endfunction

	function automatic logic [ADDR_W-1:0] live_address();
		int live[$];
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			if (shadow_owner[k] != '0) live.push_back(k);
		end
		if (live.size() == 0) return block_start($urandom_range(TOTAL_BLOCKS - 1));
		return block_start(shadow_first[live[$urandom_range(live.size() - 1)]]);
	endfunction

	// ---------------- checking ----------------

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t ns: mismatch on %s, got %0h, want %0h", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected transaction", granted_address, '0);
			end else begin
				oldest = pending_results.pop_front();
				if (granted_address !== oldest.addr)
					report_mismatch("granted_address", granted_address, oldest.addr);
				if (success !== oldest.ok)
					report_mismatch("success", success, oldest.ok);
				if (entries_released !== oldest.freed)
					report_mismatch("entries_released", entries_released, oldest.freed);
			end
		end
	end

	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold = rx_hold - 1;
			out_ready = 1'b0;
		end else begin
			out_ready = !(idle_on && $urandom_range(99) < 17);
		end
	end

	// ---------------- driving ----------------

	task automatic send_op(logic f, logic [SIZE_W-1:0] sz, logic [OWNER_W-1:0] who,
			logic [ADDR_W-1:0] at);
		if (idle_on && $urandom_range(99) < 17) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		func = f;
		size_bytes = sz;
		owner = who;
		release_address = at;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(f == FUNC_ALLOC ? grant_alloc(sz, who) : free_owner(at));
	endtask

	task automatic alloc(logic [SIZE_W-1:0] sz, logic [OWNER_W-1:0] who);
		send_op(FUNC_ALLOC, sz, who, $urandom);
	endtask

	task automatic release_at(logic [ADDR_W-1:0] at);
		send_op(FUNC_RELEASE, SIZE_W'($urandom), $urandom, at);
	endtask

	task automatic wait_results_done(int tail);
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_heap_base(logic [ADDR_W-1:0] v);
		wait_results_done(4);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		shadow_base = v;
	endtask

	task automatic random_op();
		logic [SIZE_W-1:0] sz;
		logic [OWNER_W-1:0] who;
		logic [ADDR_W-1:0] at;
		// lean toward releases when the table is close to full
		if ($urandom_range(99) < (entries_in_use() >= 10 ? 30 : 60)) begin
			case ($urandom_range(9))
				0, 1, 2, 3: sz = SIZE_W'($urandom_range(SMALL_BYTES));
				4, 5:       sz = SIZE_W'($urandom_range(LARGE_BYTES - 1, SMALL_BYTES + 1));
				6, 7, 8:    sz = SIZE_W'($urandom_range(4 * LARGE_BYTES, LARGE_BYTES));
				default:    sz = SIZE_W'($urandom);
			endcase
			if ($urandom_range(49) == 0)
				who = '0;
			else if ($urandom_range(19) == 0)
				who = $urandom;
			else
				who = $urandom_range(6, 1);
			alloc(sz, who);
		end else begin
			case ($urandom_range(7))
				0:       at = $urandom;
				1:       at = block_start($urandom_range(TOTAL_BLOCKS - 1));
				default: at = live_address();
			endcase
			release_at(at);
		end
	endtask

	// ---------------- tests ----------------

	task automatic test_size_classes();
		alloc(16'd0, 32'd1);            // small 0
		alloc(16'd512, 32'd1);          // small 1
		alloc(16'd513, 32'd2);          // large 24
		alloc(16'd1023, 32'd2);         // large 25
		alloc(16'd1024, 32'd3);         // large 26
		alloc(16'd1025, 32'd3);         // large 27..28
		alloc(16'hFFFF, 32'd4);         // needs 64 large blocks: refused
		alloc(16'd100, 32'd0);          // owner zero: refused
		alloc(16'd16, 32'hFFFF_FFFF);   // small 2
		release_at(block_start(24));    // owner 2, two entries
		release_at(block_start(28));    // inside a run, not a start: unknown
		release_at(32'h0000_0000);
		release_at(32'hFFFF_FFFF);
		alloc(16'd12288, 32'd5);        // 12 in a row not available
		alloc(16'd11264, 32'd5);        // large 29..39
		alloc(16'd700, 32'd6);          // large 24
		alloc(16'd700, 32'd6);          // large 25
		alloc(16'd900, 32'h8000_0000);  // mid-size with no large free
		alloc(16'd2048, 32'd7);         // no large run at all
	endtask

	task automatic test_table_full();
		repeat (5) alloc(16'd64, 32'd8);  // last one meets a full table
		release_at(block_start(3));
		release_at(block_start(29));
		wait_results_done(4);
	endtask

	task automatic test_base_moves();
		logic [ADDR_W-1:0] old_addr;
		old_addr = live_address();
		write_heap_base(32'hFFFF_FE00);
		release_at(old_addr);            // stale address under the new base
		alloc(16'd2048, 32'd9);          // address wraps past zero
		alloc(16'd300, 32'd9);
		release_at(live_address());
		release_at(live_address());
		wait_results_done(4);
	endtask

	task automatic test_backpressure();
		@(posedge clk);
		rx_hold = 300;
		repeat (30) random_op();
		wait (rx_hold == 0);
		wait_results_done(4);  // sender stays quiet until all responses are back
	endtask

	task automatic test_random_phase(logic [ADDR_W-1:0] base, int n, bit calm);
		write_heap_base(base);
		idle_on = !calm;
		repeat (n) random_op();
		wait_results_done(4);
		idle_on = 1'b1;
	endtask

	initial begin
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			shadow_owner[k] = '0;
			shadow_first[k] = 0;
			shadow_count[k] = 0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_size_classes();
		test_table_full();
		test_base_moves();
		test_backpressure();
		test_random_phase(32'h0000_0000, 200, 1'b1);
		test_random_phase(32'hFFFF_FFFF, 200, 1'b0);
		test_random_phase(32'hFFFF_F000, 200, 1'b0);
		test_random_phase($urandom, 200, 1'b0);
		test_random_phase(HEAP_BASE_RST, 200, 1'b0);

		wait_results_done(60);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* files.f */
hdl/tcbha_pkg.sv
hdl/tcbha_ctrl.sv
hdl/tcbha_dp.sv
hdl/two_class_block_heap_allocator.sv
bench/tb.sv
